@@ rtl/core/insertion_sorter_core_defines.svh @@
// ----------------------------------------------------------------------------
// insertion sorter assertion macros
// shared assertion forms for the insertion sorter core
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_CORE_DEFINES_SVH
`define INSERTION_SORTER_CORE_DEFINES_SVH

// property that must hold at every edge out of reset
`define ISC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ISC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/core/isc_pkg.sv @@
// ----------------------------------------------------------------------------
// isc_pkg
// shared constants and types of the insertion sorter core
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/isc_cell.sv @@
// ----------------------------------------------------------------------------
// isc_cell
// one compare-and-hold cell of the sorting chain
// ----------------------------------------------------------------------------
`default_nettype none

module isc_cell
  import isc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire data_t      new_value,
  input  wire data_t      left_value,
  input  wire logic       left_gt,
  input  wire logic       left_valid,
  input  wire data_t      right_value,
  input  wire logic       right_valid,
  output data_t           held_value,
  output logic            held_valid,
  output logic            gt
);

  data_t incoming;
  logic  take;

  // held value strictly above the new one
  assign gt       = held_valid && (held_value > new_value);
  assign incoming = left_gt ? left_value : new_value;
  // move up on greater, or fill the first empty slot
  assign take     = gt || (!held_valid && left_valid);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held_value <= right_value;
    end else if (ctrl.insert && take) begin
      held_value <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= right_valid;
    end else if (ctrl.insert && take) begin
      held_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/insertion_sorter_core.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_core
// stable ascending insertion sorter built as a row of compare-and-hold cells
// ----------------------------------------------------------------------------
// Signed 32-bit values enter one per cycle while in_ready is high; each is
// compared against every held value at once and slotted in place, larger
// values moving up one cell, equal values staying ahead of the newcomer.
// Up to DEPTH values are held; further values of the set are dropped and
// flagged through overflow on every result of that set. The transaction
// with last high is inserted like any other, then the set drains from the
// bottom cell, one result per cycle while out_ready is high, the final one
// marked by final_res. in_ready stays low from the last input until the
// final result is taken. The per-insert cycle time is bounded by the
// broadcast compare of the new value against all cells and the neighbor
// select.
`default_nettype none

`include "insertion_sorter_core_defines.svh"

module insertion_sorter_core
  import isc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  // input channel
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire data_t value,
  input  wire logic  last,
  // result channel
  output logic       out_valid,
  input  wire logic  out_ready,
  output data_t      sorted_value,
  output logic       final_res,
  output logic       overflow
);

  data_t            cell_value [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_gt;
  cell_ctrl_t       ctrl;

  logic draining;   // set is being shifted out
  logic dropped;    // a value of this set was lost
  logic in_xact;
  logic out_xact;
  logic full;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign in_ready  = !draining;
  assign in_xact   = in_valid && in_ready;
  assign out_valid = draining && cell_valid[0];
  assign out_xact  = out_valid && out_ready;

  // chain is full once the top cell holds a value
  assign full = cell_valid[DEPTH-1];

  assign ctrl.insert = in_xact && !full;
  assign ctrl.shift  = out_xact;

  // ---------------------------------------------------------------------
  // chain of cells; left feeds insertion, right feeds draining
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_value;
    logic  left_gt;
    logic  left_valid;
    data_t right_value;
    logic  right_valid;

    if (i == 0) begin : g_bottom
      // empty bottom cell always takes the new value
      assign left_value = value;
      assign left_gt    = 1'b0;
      assign left_valid = 1'b1;
    end else begin : g_mid_left
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH-1) begin : g_top
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    isc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (value),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .left_valid  (left_valid),
      .right_value (right_value),
      .right_valid (right_valid),
      .held_value  (cell_value[i]),
      .held_valid  (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // ---------------------------------------------------------------------
  // set control: drain after last, clear overflow after final result
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else if (in_xact) begin
      draining <= last;
      if (full) begin
        dropped <= 1'b1;
      end
    end else if (out_xact && final_res) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end
  end

  // results come straight from the bottom cell
  assign sorted_value = cell_value[0];
  assign final_res    = !cell_valid[1];
  assign overflow     = dropped;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  logic [DEPTH-1:0] occ_plus_one;
  assign occ_plus_one = cell_valid + {{(DEPTH-1){1'b0}}, 1'b1};

  // occupied cells always form a contiguous run from the bottom
  `ISC_ASSERT_ALWAYS(a_occ_prefix, (cell_valid & occ_plus_one) == '0, "cell occupancy has a hole")
  // the two lowest held values are in order
  `ISC_ASSERT_ALWAYS(a_bottom_order, !cell_valid[1] || (cell_value[0] <= cell_value[1]), "chain out of order")
  // a last transaction always leaves a result waiting
  `ISC_ASSERT_NEXT(a_last_drains, in_xact && last, out_valid, "no result after last transaction")
  // after the final result the block is empty and ready for a new set
  `ISC_ASSERT_NEXT(a_final_clears, out_xact && final_res, in_ready && !overflow && (cell_valid == '0), "set not cleared after final result")

endmodule

`default_nettype wire

@@ dv/insertion_sorter_core_tb.sv @@
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// insertion_sorter_core testbench
// streams sets of signed values into the sorter and checks every drained
// result in order against a software insertion sort kept in a scoreboard
// ----------------------------------------------------------------------------

class sort_tracker;

  typedef struct {
    isc_pkg::data_t val;
    logic           fin;
    logic           ovf;
  } sorted_entry_t;

  isc_pkg::data_t held_vals[isc_pkg::DEPTH];
  int             held_n;
  bit             dropped;
  sorted_entry_t  pending_results[$];
  int             errors;

  function new();
    held_n  = 0;
    dropped = 0;
    errors  = 0;
  endfunction

  // insert one accepted value; a set end queues the whole sorted set
  function void note_value(isc_pkg::data_t v, logic is_last);
    int pos;
    sorted_entry_t e;
    if (held_n >= isc_pkg::DEPTH) begin
      dropped = 1'b1;
    end else begin
      pos = held_n;
      // strictly larger values move up, so equal values stay in arrival order
      while (pos > 0 && held_vals[pos-1] > v) begin
        held_vals[pos] = held_vals[pos-1];
        pos--;
      end
      held_vals[pos] = v;
      held_n++;
    end
    if (is_last) begin
      for (int k = 0; k < held_n; k++) begin
        e.val = held_vals[k];
        e.fin = (k == held_n - 1);
        e.ovf = dropped;
        pending_results.push_back(e);
      end
      held_n  = 0;
      dropped = 1'b0;
    end
  endfunction

  function void check_result(isc_pkg::data_t got_val, logic got_fin, logic got_ovf);
    sorted_entry_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result sorted_value=%0d final_res=%0b overflow=%0b",
               $time, got_val, got_fin, got_ovf);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (got_val !== e.val) begin
      $display("%0t: sorted_value expected %0d actual %0d", $time, e.val, got_val);
      errors++;
    end
    if (got_fin !== e.fin) begin
      $display("%0t: final_res expected %0b actual %0b", $time, e.fin, got_fin);
      errors++;
    end
    if (got_ovf !== e.ovf) begin
      $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, got_ovf);
      errors++;
    end
  endfunction

endclass

module insertion_sorter_core_tb;
  import isc_pkg::*;

  localparam int ITEM_TARGET = 380;
  localparam int CYCLE_LIMIT = 200000;
  // long enough for a full set to pile up and block the next one
  localparam int LONG_HOLD   = 120;
  // quiet window after the last result to catch anything extra
  localparam int DRAIN_WAIT  = 50;

  logic  clk = 1'b0;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  data_t value;
  logic  last;
  logic  out_valid;
  logic  out_ready;
  data_t sorted_value;
  logic  final_res;
  logic  overflow;

  sort_tracker tracker = new();

  int items_sent    = 0;
  int cycle_count   = 0;
  bit long_hold_req = 1'b0;

  insertion_sorter_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // value flavors: full range, a narrow band full of duplicates, corner values
  function automatic data_t pick_value(int flavor);
    case (flavor)
      1: return data_t'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 4))
          0: return data_t'(32'h7fffffff);
          1: return data_t'(32'h80000000);
          2: return data_t'(0);
          3: return data_t'(-1);
          default: return data_t'($urandom);
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // offer one transaction and hold it until taken; valid stays up when the
  // next one follows back to back
  task automatic send_item(data_t v, logic is_last, int gap);
    in_valid <= 1'b1;
    value    <= v;
    last     <= is_last;
    do @(posedge clk); while (!in_ready);
    tracker.note_value(v, is_last);
    items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_set(int n, int flavor, bit gaps_on);
    for (int i = 0; i < n; i++) begin
      send_item(pick_value(flavor), (i == n - 1),
                (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0);
    end
  endtask

  // input side: directed corners first, then random sets
  initial begin
    data_t corner_set[6];
    int    set_no;
    int    n;
    int    r;
    in_valid <= 1'b0;
    value    <= '0;
    last     <= 1'b0;
    rst      <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // both extremes, zero, minus one and a repeated minimum in one set
    corner_set = '{data_t'(32'h7fffffff), data_t'(32'h80000000), data_t'(0),
                   data_t'(-1), data_t'(1), data_t'(32'h80000000)};
    foreach (corner_set[i]) send_item(corner_set[i], (i == 5), 0);
    // a set made of the last transaction alone
    send_item(data_t'(32'h5a5a5a5a), 1'b1, 2);
    // one more than capacity, descending with duplicate pairs; the item
    // flagged last is the one dropped
    for (int i = 0; i <= DEPTH; i++) send_item(data_t'(DEPTH - i / 2), (i == DEPTH), 0);

    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 19);
      n = (r < 14) ? $urandom_range(1, 6) :
          (r < 18) ? $urandom_range(7, DEPTH) : $urandom_range(DEPTH + 1, DEPTH + 4);
      if (set_no == 6) begin
        // let the previous set drain so the stall lands on this one
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending_results.size() != 0);
        // receiver stalls while a full set goes in back to back and the
        // next set keeps knocking on a blocked input
        long_hold_req = 1'b1;
        send_set(DEPTH, $urandom_range(0, 3), 1'b0);
      end else begin
        if (set_no == 12) begin
          // sender goes quiet until the scoreboard is empty
          in_valid <= 1'b0;
          do @(posedge clk); while (tracker.pending_results.size() != 0);
        end
        send_set(n, $urandom_range(0, 3), $urandom_range(0, 1));
      end
      set_no++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: check each transaction, then pick next cycle's ready
  initial begin
    int stall_left;
    bit choppy;
    stall_left = 0;
    choppy     = 1'b1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        tracker.check_result(sorted_value, final_res, overflow);
      end
      if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      // switch between stalling and free-running stretches now and then
      if ($urandom_range(0, 199) == 0) choppy = !choppy;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (choppy && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/isc_pkg.sv
rtl/core/isc_cell.sv
rtl/core/insertion_sorter_core.sv
dv/insertion_sorter_core_tb.sv
